[hdl/nssa_pkg.sv]
// ----------------------------------------------------------------------------
// nssa_pkg
// Shared types and constants of the sphere shell assignment block.
// ----------------------------------------------------------------------------
package nssa_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = 4;
  localparam int COORD_W     = 32;
  localparam int DIFF_W      = 33;
  localparam int SQR_W       = 66;
  localparam int LEN_W       = 34;
  localparam int REM_W       = 36;
  localparam int ROOT_STEPS  = 33;
  localparam int STEP_W      = 6;

  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic        [COORD_W-1:0] r;
  } sphere_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
  } point_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [LEN_W-1:0] gap;
  } dist_stat_t;

  typedef enum logic [2:0] {
    D_IDLE,
    D_DIFF,
    D_SQR,
    D_SUM,
    D_ROOT,
    D_FIN
  } dist_state_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_START,
    T_WAIT,
    T_OUT
  } top_state_t;

endpackage

[hdl/nssa_if.sv]
// ----------------------------------------------------------------------------
// nssa_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface nssa_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [3:0]  slot;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  logic [31:0] sphere_radius;
  logic [3:0]  old_group;

  modport source (output valid, opcode, slot, coord_x, coord_y, coord_z,
                  sphere_radius, old_group, input ready);
  modport sink (input valid, opcode, slot, coord_x, coord_y, coord_z,
                sphere_radius, old_group, output ready);
endinterface

interface nssa_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] new_group;
  logic       changed;

  modport source (output valid, new_group, changed, input ready);
  modport sink (input valid, new_group, changed, output ready);
endinterface

[hdl/nssa_cell.sv]
// ----------------------------------------------------------------------------
// nssa_cell
// One table entry of the sphere ring: loads directly or takes its neighbour.
// ----------------------------------------------------------------------------
module nssa_cell (
  input  logic             clk,
  input  logic             load_en,
  input  nssa_pkg::sphere_t load_data,
  input  logic             shift_en,
  input  nssa_pkg::sphere_t shift_in,
  output nssa_pkg::sphere_t sphere
);
  import nssa_pkg::*;

  sphere_t sphere_r;

  // entry storage, no reset: the user must not let unwritten entries be read; the block does not enforce it
  always_ff @(posedge clk) begin
    if (load_en) begin
      sphere_r <= load_data;
    end else if (shift_en) begin
      sphere_r <= shift_in;
    end
  end

  assign sphere = sphere_r;
endmodule

[hdl/nssa_dist.sv]
// ----------------------------------------------------------------------------
// nssa_dist
// Shell distance unit: differences, squares, sum, bit-serial root, abs diff.
// ----------------------------------------------------------------------------
module nssa_dist (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  nssa_pkg::point_t  point,
  input  nssa_pkg::sphere_t sphere,
  output nssa_pkg::dist_stat_t stat
);
  import nssa_pkg::*;

  dist_state_t state_r, state_nxt;
  logic signed [DIFF_W-1:0] dx_r, dy_r, dz_r;
  logic [DIFF_W-1:0]        ax, ay, az;
  logic [SQR_W-1:0]         qx_r, qy_r, qz_r;
  logic [SQR_W-1:0]         sq_r;
  logic [REM_W-1:0]         rem_r;
  logic [LEN_W-1:0]         root_r;
  logic [COORD_W-1:0]       rad_r;
  logic [LEN_W-1:0]         dist_r;
  logic [STEP_W-1:0]        step_r;
  logic [REM_W-1:0]         rem_sh;
  logic [REM_W-1:0]         trial;
  logic                     fits;
  logic                     done_flag_r;

  // magnitudes of the differences
  assign ax = dx_r[DIFF_W-1] ? DIFF_W'(-dx_r) : dx_r;
  assign ay = dy_r[DIFF_W-1] ? DIFF_W'(-dy_r) : dy_r;
  assign az = dz_r[DIFF_W-1] ? DIFF_W'(-dz_r) : dz_r;

  // one root digit per cycle
  assign rem_sh = {rem_r[REM_W-3:0], sq_r[SQR_W-1:SQR_W-2]};
  assign trial  = REM_W'({root_r, 2'b01});
  assign fits   = rem_sh >= trial;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      D_IDLE:  if (start) state_nxt = D_DIFF;
      D_DIFF:  state_nxt = D_SQR;
      D_SQR:   state_nxt = D_SUM;
      D_SUM:   state_nxt = D_ROOT;
      D_ROOT:  if (step_r == STEP_W'(ROOT_STEPS - 1)) state_nxt = D_FIN;
      D_FIN:   state_nxt = D_IDLE;
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      D_IDLE: begin
        rad_r <= sphere.r;
        dx_r  <= DIFF_W'(point.px) - DIFF_W'(sphere.cx);
        dy_r  <= DIFF_W'(point.py) - DIFF_W'(sphere.cy);
        dz_r  <= DIFF_W'(point.pz) - DIFF_W'(sphere.cz);
      end
      D_DIFF: begin
        qx_r <= ax * ax;
        qy_r <= ay * ay;
        qz_r <= az * az;
      end
      D_SQR: begin
        sq_r   <= qx_r + qy_r + qz_r;
        rem_r  <= '0;
        root_r <= '0;
        step_r <= '0;
      end
      D_ROOT: begin
        sq_r   <= {sq_r[SQR_W-3:0], 2'b00};
        rem_r  <= fits ? rem_sh - trial : rem_sh;
        root_r <= {root_r[LEN_W-2:0], fits};
        step_r <= step_r + 1'b1;
      end
      D_FIN: begin
        dist_r <= (root_r >= LEN_W'(rad_r)) ? root_r - LEN_W'(rad_r)
                                            : LEN_W'(rad_r) - root_r;
      end
      default: ;
    endcase
  end

  assign stat.busy = state_r != D_IDLE;
  assign stat.done = (state_r == D_IDLE) && (step_r == STEP_W'(ROOT_STEPS)) &&
                     done_flag_r;
  assign stat.gap  = dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_flag_r <= 1'b0;
    end else begin
      done_flag_r <= state_r == D_FIN;
    end
  end
endmodule

[hdl/nearest_sphere_shell_assign.sv]
// ----------------------------------------------------------------------------
// nearest_sphere_shell_assign
// Nearest sphere shell assignment over a rotating ring of sphere cells.
// ----------------------------------------------------------------------------
// items are taken one at a time; a load item writes its cell directly, and a
//   classify item runs each active sphere through the shared distance unit:
//   start, difference, square, sum, root digits, finish and compare
// reset: synchronous active low, clears control; sphere cells are not cleared
module nearest_sphere_shell_assign #(
  parameter int SPHERES = 16
) (
  input  logic clk,
  input  logic rst_n,
  nssa_in_if.sink    in_item,
  nssa_out_if.source out_item
);
  import nssa_pkg::*;

  localparam int ACTIVE = (SPHERES < TABLE_DEPTH) ? SPHERES : TABLE_DEPTH;

  top_state_t       state_r, state_nxt;
  sphere_t          cell_q [ACTIVE];
  logic             shift_en;
  logic             in_acc;
  point_t           point_r;
  logic [IDX_W-1:0] old_r;
  logic [IDX_W-1:0] grp_r;
  logic [IDX_W-1:0] k_r;
  logic [LEN_W-1:0] best_d_r, g_d_r;
  logic [IDX_W-1:0] best_r;
  logic             out_valid_r;
  logic [IDX_W-1:0] out_grp_r;
  logic             out_chg_r;
  logic             start;
  logic             k_last;
  logic [IDX_W-1:0] final_grp;
  dist_stat_t       dst;
  sphere_t          load_data;

  assign in_acc    = in_item.valid && in_item.ready;
  assign load_data = '{cx: in_item.coord_x, cy: in_item.coord_y,
                       cz: in_item.coord_z, r: in_item.sphere_radius};

  // ring of sphere cells, cell 0 feeds the distance unit
  for (genvar i = 0; i < ACTIVE; i++) begin : g_cell
    nssa_cell u_cell (
      .clk       (clk),
      .load_en   (in_acc && (in_item.opcode == OP_LOAD) &&
                  (in_item.slot == IDX_W'(i))),
      .load_data (load_data),
      .shift_en  (shift_en),
      .shift_in  (cell_q[(i + 1) % ACTIVE]),
      .sphere    (cell_q[i])
    );
  end

  nssa_dist u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .point  (point_r),
    .sphere (cell_q[0]),
    .stat   (dst)
  );

  assign k_last    = k_r == IDX_W'(ACTIVE - 1);
  assign final_grp = (g_d_r == best_d_r) ? grp_r : best_r;

  // control
  always_comb begin
    state_nxt     = state_r;
    start         = 1'b0;
    shift_en      = 1'b0;
    in_item.ready = 1'b0;
    case (state_r)
      T_IDLE: begin
        in_item.ready = 1'b1;
        if (in_item.valid && in_item.opcode == OP_CLASSIFY) state_nxt = T_START;
      end
      T_START: begin
        start     = 1'b1;
        state_nxt = T_WAIT;
      end
      T_WAIT: begin
        if (dst.done) begin
          shift_en  = 1'b1;
          state_nxt = k_last ? T_OUT : T_START;
        end
      end
      T_OUT: begin
        if (!out_valid_r || out_item.ready) state_nxt = T_IDLE;
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // scan bookkeeping
  always_ff @(posedge clk) begin
    if (state_r == T_IDLE && in_acc) begin
      point_r <= '{px: in_item.coord_x, py: in_item.coord_y, pz: in_item.coord_z};
      old_r   <= in_item.old_group;
      grp_r   <= (32'(in_item.old_group) < ACTIVE) ? in_item.old_group : '0;
      k_r     <= '0;
    end else if (state_r == T_WAIT && dst.done) begin
      if (k_r == '0 || dst.gap < best_d_r) begin
        best_d_r <= dst.gap;
        best_r   <= k_r;
      end
      if (k_r == grp_r) g_d_r <= dst.gap;
      k_r <= k_r + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == T_OUT && (!out_valid_r || out_item.ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_item.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == T_OUT && (!out_valid_r || out_item.ready)) begin
      out_grp_r <= final_grp;
      out_chg_r <= final_grp != old_r;
    end
  end

  assign out_item.valid     = out_valid_r;
  assign out_item.new_group = out_grp_r;
  assign out_item.changed   = out_chg_r;

  // checks
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    dst.done |-> state_r == T_WAIT)
    else $error("distance done outside scan");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == T_WAIT |-> 32'(k_r) < ACTIVE)
    else $error("scan index past active spheres");

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !dst.busy)
    else $error("distance unit started while busy");

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> 32'(out_grp_r) < ACTIVE)
    else $error("result group not active");
endmodule

[bench/nearest_sphere_shell_assign_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_sphere_shell_assign_tb
// Self-checking bench for the sphere shell assignment block. All sixteen
// spheres are loaded first, then a directed table of loads and classifies and
// a random mix of both are sent in bursts. Each accepted classify is predicted
// by a local copy of the sphere table and the exact shell distance (a typed row
// gives it directly), and each result is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module nearest_sphere_shell_assign_tb;
  import nssa_pkg::*;

  localparam int N_SPHERES  = 16;
  localparam int HOLD_OFF   = 2000;
  localparam int RAND_ITEMS = 600;

  typedef struct {
    logic        opcode;
    logic [3:0]  slot;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] r;
    logic [3:0]  og;
    bit          typed;
    logic [3:0]  eg;
    logic        ec;
  } stim_row_t;

  typedef struct {
    logic [3:0] group;
    logic       changed;
  } assign_t;

  logic clk;
  logic rst_n;
  nssa_in_if  in_ch ();
  nssa_out_if out_ch ();

  nearest_sphere_shell_assign #(.SPHERES(N_SPHERES)) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_ch.sink),
    .out_item(out_ch.source)
  );

  sphere_t   spheres [N_SPHERES];
  assign_t   pending_assigns[$];
  stim_row_t rows[$];
  int        errors;
  int        results_seen;

  // clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // exact floor square root of a 66-bit value, one bit per step
  function automatic logic [33:0] floor_root(logic [65:0] v);
    logic [67:0] rem;
    logic [67:0] trial;
    logic [33:0] root;
    rem  = '0;
    root = '0;
    for (int i = 32; i >= 0; i--) begin
      rem   = (rem << 2) | 68'(v[2*i +: 2]);
      trial = (68'(root) << 2) | 68'd1;
      root  = root << 1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = root | 34'd1;
      end
    end
    return root;
  endfunction

  function automatic logic [65:0] sq_diff(logic [31:0] a, logic [31:0] b);
    logic signed [32:0] d;
    logic [32:0]        m;
    d = $signed({a[31], a}) - $signed({b[31], b});
    m = d[32] ? 33'(-d) : 33'(d);
    return 66'(m) * 66'(m);
  endfunction

  function automatic logic [33:0] shell_gap(sphere_t s, logic [31:0] x, logic [31:0] y,
                                            logic [31:0] z);
    logic [65:0] sum;
    logic [33:0] len;
    sum = sq_diff(x, s.cx) + sq_diff(y, s.cy) + sq_diff(z, s.cz);
    len = floor_root(sum);
    return (len >= 34'(s.r)) ? len - 34'(s.r) : 34'(s.r) - len;
  endfunction

  // prediction of one accepted item
  function automatic void track_item(stim_row_t it);
    assign_t     a;
    logic [3:0]  best;
    logic [33:0] best_d;
    logic [33:0] d;
    if (it.opcode == OP_LOAD) begin
      spheres[it.slot] = '{cx: it.x, cy: it.y, cz: it.z, r: it.r};
      return;
    end
    best   = it.og;
    best_d = shell_gap(spheres[best], it.x, it.y, it.z);
    for (int k = 0; k < N_SPHERES; k++) begin
      d = shell_gap(spheres[k], it.x, it.y, it.z);
      if (d < best_d) begin
        best_d = d;
        best   = 4'(k);
      end
    end
    a.group   = best;
    a.changed = (best != it.og);
    if (it.typed) begin
      a.group   = it.eg;
      a.changed = it.ec;
    end
    pending_assigns = {pending_assigns, a};
  endfunction

  function automatic stim_row_t mk(logic op, logic [3:0] slot, logic [31:0] x,
                                   logic [31:0] y, logic [31:0] z, logic [31:0] r,
                                   logic [3:0] og);
    stim_row_t s;
    s = '{opcode: op, slot: slot, x: x, y: y, z: z, r: r, og: og,
          typed: 1'b0, eg: '0, ec: 1'b0};
    return s;
  endfunction

  // coordinate: full range, near the origin or an extreme
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_radius();
    case ($urandom_range(0, 7))
      0, 1:    return $urandom;
      2:       return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
      default: return $urandom_range(0, 32'h0020_0000);
    endcase
  endfunction

  function automatic stim_row_t rand_item();
    stim_row_t   s;
    logic [3:0]  k;
    if ($urandom_range(0, 9) < 4) begin
      s = mk(OP_LOAD, 4'($urandom), rand_coord(), rand_coord(), rand_coord(),
             rand_radius(), 4'($urandom));
      // sometimes a copy of another sphere, so that ties occur
      if ($urandom_range(0, 5) == 0) begin
        k   = 4'($urandom);
        s.x = spheres[k].cx;
        s.y = spheres[k].cy;
        s.z = spheres[k].cz;
        s.r = spheres[k].r;
      end
    end else begin
      s = mk(OP_CLASSIFY, 4'($urandom), rand_coord(), rand_coord(), rand_coord(),
             $urandom, 4'($urandom));
      // sometimes the point sits on a sphere centre
      if ($urandom_range(0, 4) == 0) begin
        k   = 4'($urandom);
        s.x = spheres[k].cx;
        s.y = spheres[k].cy;
        s.z = spheres[k].cz;
      end
    end
    return s;
  endfunction

  // one item through the input channel, with a random gap first if gap is set
  task automatic send_item(stim_row_t it, bit gap);
    if (gap) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= it.opcode;
    in_ch.slot          <= it.slot;
    in_ch.coord_x       <= it.x;
    in_ch.coord_y       <= it.y;
    in_ch.coord_z       <= it.z;
    in_ch.sphere_radius <= it.r;
    in_ch.old_group     <= it.og;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    track_item(it);
  endtask

  // stimulus
  initial begin
    stim_row_t s;
    int        burst;
    int        waited;
    errors              = 0;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.opcode        = OP_LOAD;
    in_ch.slot          = '0;
    in_ch.coord_x       = '0;
    in_ch.coord_y       = '0;
    in_ch.coord_z       = '0;
    in_ch.sphere_radius = '0;
    in_ch.old_group     = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: every slot loaded before the first classify
    rows = {rows, mk(OP_LOAD, 4'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h0, 4'd0)};
    rows = {rows, mk(OP_LOAD, 4'd1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                     32'hffff_ffff, 4'd15)};
    for (int k = 2; k < N_SPHERES; k++)
      rows = {rows, mk(OP_LOAD, 4'(k), 32'(k) << 20, 32'h0, 32'h0, 32'(k) << 16,
                       4'd0)};
    // point on the centre of a zero-radius sphere: that sphere wins outright
    s       = mk(OP_CLASSIFY, 4'd9, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'hffff_ffff, 4'd5);
    s.typed = 1'b1;
    s.eg    = 4'd0;
    s.ec    = 1'b1;
    rows = {rows, s};
    rows = {rows, mk(OP_CLASSIFY, 4'd0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                     32'h0, 4'd1)};
    rows = {rows, mk(OP_CLASSIFY, 4'd15, 32'h0, 32'h0, 32'h0, 32'h0, 4'd15)};
    rows = {rows, mk(OP_CLASSIFY, 4'd3, 32'h0020_0000, 32'h0, 32'h0, 32'h0, 4'd2)};
    // equal spheres: the current group is kept on a tie
    rows = {rows, mk(OP_LOAD, 4'd3, 32'h0020_0000, 32'h0, 32'h0, 32'h0002_0000,
                     4'd0)};
    rows = {rows, mk(OP_CLASSIFY, 4'd0, 32'h0020_0000, 32'h0, 32'h0, 32'h0, 4'd3)};
    rows = {rows, mk(OP_CLASSIFY, 4'd0, 32'h0020_0000, 32'h0, 32'h0, 32'h0, 4'd2)};

    foreach (rows[i]) send_item(rows[i], $urandom_range(0, 2) == 0);

    // random part in bursts
    burst = 0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (burst == 0) burst = $urandom_range(1, 12);
      burst--;
      send_item(rand_item(), burst == 0);
    end
    in_ch.valid <= 1'b0;

    // drain
    waited = 0;
    while (pending_assigns.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_assigns.size() == 0) begin
      $display("[nearest_sphere_shell_assign] OK");
    end else begin
      $display("[nearest_sphere_shell_assign] ERROR");
    end
    $finish;
  end

  // receiver: one long hold-off early on, then stretches of free flow and stalls
  initial begin
    int phase;
    out_ch.ready = 1'b0;
    phase        = 0;
    @(posedge rst_n);
    while (results_seen < 3) begin
      @(posedge clk);
      out_ch.ready <= 1'b1;
    end
    out_ch.ready <= 1'b0;
    repeat (HOLD_OFF) @(posedge clk);
    forever begin
      phase = (phase + 1) % 256;
      out_ch.ready <= (phase < 64) ? 1'b1 : ($urandom_range(0, 2) != 0);
      @(posedge clk);
    end
  end

  // result check
  initial results_seen = 0;
  always @(posedge clk) begin
    assign_t a;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_assigns.size() == 0) begin
        $error("unexpected result item: new_group %0d changed %0d",
               out_ch.new_group, out_ch.changed);
        errors++;
      end else begin
        a = pending_assigns.pop_front();
        if (out_ch.new_group !== a.group) begin
          $error("new_group: expected %0d, actual %0d", a.group, out_ch.new_group);
          errors++;
        end
        if (out_ch.changed !== a.changed) begin
          $error("changed: expected %0d, actual %0d", a.changed, out_ch.changed);
          errors++;
        end
      end
    end
  end

  // overall limit
  initial begin
    #20_000_000;
    $display("[nearest_sphere_shell_assign] ERROR");
    $finish;
  end

endmodule
